// ===== sv/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtt_pkg: shared types, constants and helpers for integer_to_radix_text
// Holds the transaction structs, the digit-to-ASCII helper and the sizing
// constants that the converter, divider, digit store and emitter all use.
// ----------------------------------------------------------------------------
package rtt_pkg;

    // Sizing
    localparam int VALUE_BITS         = 32;
    localparam int MAX_OUT_CHARS      = 64;
    localparam int MIN_BASE           = 2;
    localparam int MAX_BASE           = 36;
    localparam int MAX_PREC           = MAX_OUT_CHARS - 4;
    localparam int PREFIX_X_INDEX     = 33;
    localparam int BASE_W             = 6;
    localparam int REM_W              = 6;
    localparam int DIV_BITS_PER_CYCLE = 8;
    localparam int DIV_W              = ((VALUE_BITS + DIV_BITS_PER_CYCLE - 1)
                                         / DIV_BITS_PER_CYCLE) * DIV_BITS_PER_CYCLE;
    localparam int DIV_CYCLES         = DIV_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES + 1);
    localparam int DIG_IDX_W          = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W          = $clog2(VALUE_BITS + 1);
    localparam int CNT_W              = $clog2(MAX_OUT_CHARS + 1);

    // ASCII codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    // Input transaction
    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  base;
        logic [6:0]  width;
        logic [5:0]  precision;
        logic        is_signed;
        logic        plus_sign;
        logic        space_sign;
        logic        left_justify;
        logic        zero_pad;
        logic        alt_prefix;
        logic        upper_case;
    } rtt_in_t;

    // Result transaction
    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic       error;
    } rtt_out_t;

    // Layout of one formatted run, handed from the converter to the emitter
    typedef struct packed {
        logic                 err;
        logic                 upper;
        logic [7:0]           sign_char;
        logic                 sign_n;
        logic                 pfx0_n;
        logic                 pfxx_n;
        logic [CNT_W-1:0]     padl;
        logic [CNT_W-1:0]     zpad;
        logic [CNT_W-1:0]     precz;
        logic [CNT_W-1:0]     padr;
        logic [DIG_CNT_W-1:0] ndig;
        logic [CNT_W-1:0]     total;
    } rtt_plan_t;

    // Map a digit value 0..35 to its ASCII character
    function automatic logic [7:0] digit_char(input logic [REM_W-1:0] d, input logic upper);
        logic [7:0] d8;
        d8 = {{(8 - REM_W){1'b0}}, d};
        if (d8 < 8'd10) begin
            return CH_ZERO + d8;
        end
        return (upper ? CH_UPPER_A : CH_LOWER_A) + d8 - 8'd10;
    endfunction

endpackage

// ===== sv/rtt_div_unit.sv =====
// ----------------------------------------------------------------------------
// rtt_div_unit: iterative divider by the conversion base
// Restoring division, DIV_BITS_PER_CYCLE quotient bits per cycle. A start
// pulse loads the dividend; done pulses once quotient and remainder are valid.
// ----------------------------------------------------------------------------
module rtt_div_unit
    import rtt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [BASE_W-1:0]     base,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [REM_W-1:0]      remainder
);

    logic [DIV_W-1:0]     work_reg, work_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [BASE_W-1:0]    base_reg, base_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    // Shift dividend bits into the remainder, subtract the base where it fits
    always_comb begin
        logic [REM_W:0]   trial;
        logic [REM_W-1:0] r;
        logic [DIV_W-1:0] w;
        r         = rem_reg;
        w         = work_reg;
        trial     = '0;
        work_next = work_reg;
        rem_next  = rem_reg;
        base_next = base_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            work_next = DIV_W'(dividend);
            rem_next  = '0;
            base_next = base;
            cnt_next  = DIV_CNT_W'(DIV_CYCLES);
        end else if (cnt_reg != '0) begin
            for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
                trial = {r, w[DIV_W-1]};
                w     = {w[DIV_W-2:0], 1'b0};
                if (trial >= {1'b0, base_reg}) begin
                    trial = trial - {1'b0, base_reg};
                    w[0]  = 1'b1;
                end
                r = trial[REM_W-1:0];
            end
            work_next = w;
            rem_next  = r;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
    end

    assign done      = done_reg;
    assign quotient  = work_reg[VALUE_BITS-1:0];
    assign remainder = rem_reg;

endmodule

// ===== sv/rtt_digit_store.sv =====
// ----------------------------------------------------------------------------
// rtt_digit_store: digit buffer
// Holds the digits of one value, least significant first, as the divider
// produces them; the emitter reads them back most significant first.
// ----------------------------------------------------------------------------
module rtt_digit_store
    import rtt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [DIG_IDX_W-1:0] wr_idx,
    input  logic [REM_W-1:0]     wr_digit,
    input  logic [DIG_IDX_W-1:0] rd_idx,
    output logic [REM_W-1:0]     rd_digit
);

    logic [REM_W-1:0] digit_reg [VALUE_BITS];

    // Write one digit per divider pass
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            digit_reg[wr_idx] <= wr_digit;
        end
    end

    assign rd_digit = digit_reg[rd_idx];

endmodule

// ===== sv/rtt_emit_seq.sv =====
// ----------------------------------------------------------------------------
// rtt_emit_seq: character emitter
// Walks the layout phases (padding, sign, prefix, zeros, digits, padding), or a lone
// error phase, and drives one character per result transaction through an output register.
// ----------------------------------------------------------------------------
module rtt_emit_seq
    import rtt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  rtt_plan_t            plan,
    input  logic [REM_W-1:0]     rd_digit,
    output logic [DIG_IDX_W-1:0] rd_idx,
    output logic                 busy,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rtt_out_t             m_data
);

    typedef enum logic [9:0] {
        PH_IDLE = 10'b00_0000_0001,
        PH_ERR  = 10'b00_0000_0010,
        PH_PADL = 10'b00_0000_0100,
        PH_SIGN = 10'b00_0000_1000,
        PH_PFX0 = 10'b00_0001_0000,
        PH_PFXX = 10'b00_0010_0000,
        PH_ZPAD = 10'b00_0100_0000,
        PH_PREC = 10'b00_1000_0000,
        PH_DIGS = 10'b01_0000_0000,
        PH_PADR = 10'b10_0000_0000
    } phase_t;

    phase_t               phase_reg, phase_next, phase_after;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [DIG_IDX_W-1:0] dig_idx_reg, dig_idx_next;
    rtt_plan_t            plan_reg, plan_next;
    logic                 m_valid_reg, m_valid_next;
    rtt_out_t             m_data_reg, m_data_next;
    logic                 out_free;
    logic                 emit;
    logic                 advance;
    logic [7:0]           char_sel;
    logic [DIG_CNT_W-1:0] ndig_m1;

    // Characters still owed in a given phase
    function automatic logic [CNT_W-1:0] phase_count(input phase_t ph, input rtt_plan_t p);
        logic [CNT_W-1:0] n;
        unique case (ph)
            PH_ERR:  n = CNT_W'(1);
            PH_PADL: n = p.padl;
            PH_SIGN: n = CNT_W'(p.sign_n);
            PH_PFX0: n = CNT_W'(p.pfx0_n);
            PH_PFXX: n = CNT_W'(p.pfxx_n);
            PH_ZPAD: n = p.zpad;
            PH_PREC: n = p.precz;
            PH_DIGS: n = CNT_W'(p.ndig);
            PH_PADR: n = p.padr;
            default: n = '0;
        endcase
        return n;
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (phase_reg != PH_IDLE) && (cnt_reg != '0) && out_free;
    assign advance  = (phase_reg != PH_IDLE)
                      && ((cnt_reg == '0) || (emit && cnt_reg == CNT_W'(1)));
    assign ndig_m1  = plan.ndig - 1'b1;

    // Phase order of the formatted text
    always_comb begin
        unique case (phase_reg)
            PH_PADL: phase_after = PH_SIGN;
            PH_SIGN: phase_after = PH_PFX0;
            PH_PFX0: phase_after = PH_PFXX;
            PH_PFXX: phase_after = PH_ZPAD;
            PH_ZPAD: phase_after = PH_PREC;
            PH_PREC: phase_after = PH_DIGS;
            PH_DIGS: phase_after = PH_PADR;
            default: phase_after = PH_IDLE;
        endcase
    end

    // Select the character for the current phase
    always_comb begin
        unique case (phase_reg)
            PH_PADL, PH_PADR:          char_sel = CH_SPACE;
            PH_SIGN:                   char_sel = plan_reg.sign_char;
            PH_PFX0, PH_ZPAD, PH_PREC: char_sel = CH_ZERO;
            PH_PFXX:                   char_sel = digit_char(REM_W'(PREFIX_X_INDEX),
                                                             plan_reg.upper);
            PH_DIGS:                   char_sel = digit_char(rd_digit, plan_reg.upper);
            default:                   char_sel = CH_NUL;
        endcase
    end

    // Sequence the phases and fill the output register
    always_comb begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        dig_idx_next = dig_idx_reg;
        plan_next    = plan_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (start) begin
            plan_next    = plan;
            phase_next   = plan.err ? PH_ERR : PH_PADL;
            cnt_next     = plan.err ? CNT_W'(1) : plan.padl;
            rem_next     = plan.err ? CNT_W'(1) : plan.total;
            dig_idx_next = ndig_m1[DIG_IDX_W-1:0];
        end else begin
            if (emit) begin
                m_valid_next          = 1'b1;
                m_data_next.character = char_sel;
                m_data_next.last      = (rem_reg == CNT_W'(1));
                m_data_next.error     = (phase_reg == PH_ERR);
                cnt_next              = cnt_reg - 1'b1;
                rem_next              = rem_reg - 1'b1;
                if (phase_reg == PH_DIGS) begin
                    dig_idx_next = dig_idx_reg - 1'b1;
                end
            end
            if (advance) begin
                phase_next = phase_after;
                cnt_next   = phase_count(phase_after, plan_reg);
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        dig_idx_reg <= dig_idx_next;
        plan_reg    <= plan_next;
        m_data_reg  <= m_data_next;
    end

    assign rd_idx  = dig_idx_reg;
    assign busy    = (phase_reg != PH_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/integer_to_radix_text.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_text: printf-style integer to ASCII text, base 2 to 36
// Each digit is one pass of the shared divider; an invalid base skips the divider and
// yields a single error result. Items are taken one at a time: s_ready returns in the
// cycle after the emitter goes idle. Reset clears all control state.
// ----------------------------------------------------------------------------
module integer_to_radix_text
    import rtt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rtt_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rtt_out_t m_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_PLAN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic                 go_reg, go_next;
    logic                 err_reg, err_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [BASE_W-1:0]    base_reg, base_next;
    logic [DIG_CNT_W-1:0] ndig_reg, ndig_next;
    logic [CNT_W-1:0]     width_reg, width_next;
    logic [CNT_W-1:0]     prec_reg, prec_next;
    logic [7:0]           sign_char_reg, sign_char_next;
    logic                 sign_n_reg, sign_n_next;
    logic [1:0]           pfx_n_reg, pfx_n_next;
    logic                 left_reg, left_next;
    logic                 zero_reg, zero_next;
    logic                 upper_reg, upper_next;

    logic                  accept;
    logic                  base_ok;
    logic [VALUE_BITS-1:0] in_val;
    logic                  in_neg;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [REM_W-1:0]      div_rem;
    logic                  digit_wr;
    logic [DIG_IDX_W-1:0]  rd_idx;
    logic [REM_W-1:0]      rd_digit;
    logic                  emit_start;
    logic                  emit_busy;
    rtt_plan_t             plan;
    logic [CNT_W-1:0]      nprec;
    logic [CNT_W-1:0]      body;
    logic [CNT_W-1:0]      pad;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign base_ok  = (s_data.base >= BASE_W'(MIN_BASE)) && (s_data.base <= BASE_W'(MAX_BASE));
    assign in_val   = s_data.value[VALUE_BITS-1:0];
    assign in_neg   = s_data.is_signed && in_val[VALUE_BITS-1];
    assign digit_wr = (state_reg == ST_DIV) && div_done;

    // Shared divider: one pass per digit
    rtt_div_unit u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (go_reg),
        .dividend  (val_reg),
        .base      (base_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    rtt_digit_store u_digits (
        .aclk     (aclk),
        .wr_en    (digit_wr),
        .wr_idx   (ndig_reg[DIG_IDX_W-1:0]),
        .wr_digit (div_rem),
        .rd_idx   (rd_idx),
        .rd_digit (rd_digit)
    );

    // Lay out the run from the digit count and the captured controls
    always_comb begin
        nprec = (prec_reg > CNT_W'(ndig_reg)) ? prec_reg : CNT_W'(ndig_reg);
        body  = nprec + CNT_W'(sign_n_reg) + CNT_W'(pfx_n_reg);
        pad   = (width_reg > body) ? (width_reg - body) : '0;

        plan.err       = err_reg;
        plan.upper     = upper_reg;
        plan.sign_char = sign_char_reg;
        plan.sign_n    = sign_n_reg;
        plan.pfx0_n    = (pfx_n_reg != 2'd0);
        plan.pfxx_n    = (pfx_n_reg == 2'd2);
        plan.padl      = (!left_reg && !zero_reg) ? pad : '0;
        plan.zpad      = zero_reg ? pad : '0;
        plan.padr      = left_reg ? pad : '0;
        plan.precz     = nprec - CNT_W'(ndig_reg);
        plan.ndig      = ndig_reg;
        plan.total     = body + pad;
    end

    assign emit_start = (state_reg == ST_PLAN);

    rtt_emit_seq u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (emit_start),
        .plan     (plan),
        .rd_digit (rd_digit),
        .rd_idx   (rd_idx),
        .busy     (emit_busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Sequencer: capture, divide digit by digit, plan, hand off to the emitter
    always_comb begin
        state_next     = state_reg;
        go_next        = 1'b0;
        err_next       = err_reg;
        val_next       = val_reg;
        base_next      = base_reg;
        ndig_next      = ndig_reg;
        width_next     = width_reg;
        prec_next      = prec_reg;
        sign_char_next = sign_char_reg;
        sign_n_next    = sign_n_reg;
        pfx_n_next     = pfx_n_reg;
        left_next      = left_reg;
        zero_next      = zero_reg;
        upper_next     = upper_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    err_next   = !base_ok;
                    val_next   = in_neg ? (~in_val + 1'b1) : in_val;
                    base_next  = s_data.base;
                    ndig_next  = '0;
                    width_next = (s_data.width > 7'(MAX_OUT_CHARS))
                                 ? CNT_W'(MAX_OUT_CHARS) : CNT_W'(s_data.width);
                    prec_next  = (s_data.precision > 6'(MAX_PREC))
                                 ? CNT_W'(MAX_PREC) : CNT_W'(s_data.precision);
                    left_next  = s_data.left_justify;
                    zero_next  = s_data.zero_pad && !s_data.left_justify;
                    upper_next = s_data.upper_case;
                    if (in_neg) begin
                        sign_char_next = CH_MINUS;
                        sign_n_next    = 1'b1;
                    end else if (s_data.is_signed && s_data.plus_sign) begin
                        sign_char_next = CH_PLUS;
                        sign_n_next    = 1'b1;
                    end else if (s_data.is_signed && s_data.space_sign) begin
                        sign_char_next = CH_SPACE;
                        sign_n_next    = 1'b1;
                    end else begin
                        sign_char_next = CH_NUL;
                        sign_n_next    = 1'b0;
                    end
                    if (s_data.alt_prefix && s_data.base == BASE_W'(16)) begin
                        pfx_n_next = 2'd2;
                    end else if (s_data.alt_prefix && s_data.base == BASE_W'(8)) begin
                        pfx_n_next = 2'd1;
                    end else begin
                        pfx_n_next = 2'd0;
                    end
                    if (base_ok) begin
                        state_next = ST_DIV;
                        go_next    = 1'b1;
                    end else begin
                        state_next = ST_PLAN;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    val_next  = div_quot;
                    ndig_next = ndig_reg + 1'b1;
                    if (div_quot == '0 || ndig_reg == DIG_CNT_W'(VALUE_BITS - 1)) begin
                        state_next = ST_PLAN;
                    end else begin
                        go_next = 1'b1;
                    end
                end
            end
            ST_PLAN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!emit_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            go_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg    <= go_next;
        end
    end

    // Captured item and conversion progress
    always_ff @(posedge aclk) begin
        err_reg       <= err_next;
        val_reg       <= val_next;
        base_reg      <= base_next;
        ndig_reg      <= ndig_next;
        width_reg     <= width_next;
        prec_reg      <= prec_next;
        sign_char_reg <= sign_char_next;
        sign_n_reg    <= sign_n_next;
        pfx_n_reg     <= pfx_n_next;
        left_reg      <= left_next;
        zero_reg      <= zero_next;
        upper_reg     <= upper_next;
    end

endmodule

// ===== dv/integer_to_radix_text_tb.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_text_tb: self-checking bench for the radix text converter
// Feeds a short table of hand-picked conversions and then several hundred
// random ones. An in-bench formatter computes the expected text of the random
// items and some table rows, the other rows giving it as text or an error, and each
// character on the result channel is compared against it. Both channels idle at
// random, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module integer_to_radix_text_tb
    import rtt_pkg::*;
();

    localparam int    RANDOM_ITEMS = 500;
    localparam int    HOLD_CYCLES  = 400;
    localparam int    DRAIN_CYCLES = 300;
    localparam int    STALL_LIMIT  = 5000;
    localparam int    MAX_REPORTS  = 10;
    localparam string LOWER_DIGITS = "0123456789abcdefghijklmnopqrstuvwxyz";
    localparam string UPPER_DIGITS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    // Flag bits in struct order: signed, plus, space, left, zero, alt, upper
    localparam logic [6:0] FL_NONE   = 7'b0000000;
    localparam logic [6:0] FL_SIGNED = 7'b1000000;
    localparam logic [6:0] FL_PLUS   = 7'b0100000;
    localparam logic [6:0] FL_SPACE  = 7'b0010000;
    localparam logic [6:0] FL_LEFT   = 7'b0001000;
    localparam logic [6:0] FL_ZERO   = 7'b0000100;
    localparam logic [6:0] FL_ALT    = 7'b0000010;
    localparam logic [6:0] FL_UPPER  = 7'b0000001;

    // How a table row gets its expected text
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TEXT,
        ROW_ERROR
    } row_kind_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    rtt_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    rtt_out_t m_data;

    rtt_out_t  expected_chars[$];
    rtt_in_t   table_items[$];
    row_kind_t table_kinds[$];
    string     table_texts[$];

    int mismatches    = 0;
    int chars_checked = 0;
    int items_sent    = 0;
    int bad_base_sent = 0;
    int stall_cycles  = 0;
    bit idle_on       = 1'b1;
    bit hold_results  = 1'b0;

    integer_to_radix_text DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic rtt_in_t item_of(input logic [31:0] v, input logic [5:0] b,
                                        input logic [6:0] w, input logic [5:0] p,
                                        input logic [6:0] flags);
        return rtt_in_t'({v, b, w, p, flags});
    endfunction

    // Queue one result per character, marking the final one
    function automatic void expect_chars(input byte unsigned chars[$]);
        rtt_out_t r;
        foreach (chars[i]) begin
            r.character = chars[i];
            r.last      = (i == chars.size() - 1);
            r.error     = 1'b0;
            expected_chars.push_back(r);
        end
    endfunction

    function automatic void expect_text(input string s);
        byte unsigned chars[$];
        for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
        expect_chars(chars);
    endfunction

    function automatic void expect_error();
        rtt_out_t r;
        r.character = CH_NUL;
        r.last      = 1'b1;
        r.error     = 1'b1;
        expected_chars.push_back(r);
    endfunction

    // Format one integer the printf way and queue its characters, or an error for a bad base
    function automatic void predict_radix_text(input rtt_in_t it);
        byte unsigned text[$];
        byte unsigned digs[$];
        logic [VALUE_BITS-1:0] mag;
        byte unsigned sign_ch;
        int field, min_digits, ndig, padding, prefix_len;
        logic zero_fill;
        string digit_set;
        if (it.base < MIN_BASE || it.base > MAX_BASE) begin
            expect_error();
            return;
        end
        field      = (it.width > MAX_OUT_CHARS) ? MAX_OUT_CHARS : int'(it.width);
        min_digits = (it.precision > MAX_PREC) ? MAX_PREC : int'(it.precision);
        zero_fill  = it.zero_pad && !it.left_justify;
        digit_set  = it.upper_case ? UPPER_DIGITS : LOWER_DIGITS;

        // Work out sign and magnitude
        mag     = it.value[VALUE_BITS-1:0];
        sign_ch = 8'd0;
        if (it.is_signed) begin
            if (mag[VALUE_BITS-1]) begin
                sign_ch = "-";
                mag     = -mag;
            end else if (it.plus_sign) begin
                sign_ch = "+";
            end else if (it.space_sign) begin
                sign_ch = " ";
            end
        end

        // Peel digits, most significant ends up first
        do begin
            digs.push_front(digit_set[mag % it.base]);
            mag = mag / it.base;
        end while (mag != 0);
        ndig = digs.size();
        if (min_digits < ndig) min_digits = ndig;

        prefix_len = !it.alt_prefix ? 0 : (it.base == 16) ? 2 : (it.base == 8) ? 1 : 0;
        padding    = field - min_digits - ((sign_ch != 0) ? 1 : 0) - prefix_len;
        if (padding < 0) padding = 0;

        // Lay out the field
        if (!it.left_justify && !zero_fill) repeat (padding) text.push_back(" ");
        if (sign_ch != 0) text.push_back(sign_ch);
        if (prefix_len > 0) text.push_back("0");
        if (prefix_len == 2) text.push_back(digit_set[PREFIX_X_INDEX]);
        if (zero_fill) repeat (padding) text.push_back("0");
        repeat (min_digits - ndig) text.push_back("0");
        foreach (digs[i]) text.push_back(digs[i]);
        if (it.left_justify) repeat (padding) text.push_back(" ");
        while (text.size() > MAX_OUT_CHARS) void'(text.pop_back());
        expect_chars(text);
    endfunction

    function automatic void add_row(input rtt_in_t it, input row_kind_t kind, input string s);
        table_items.push_back(it);
        table_kinds.push_back(kind);
        table_texts.push_back(s);
    endfunction

    // Hand-picked conversions: extremes, every flag and the corner cases
    function automatic void build_table();
        add_row(item_of(32'd0, 6'd10, 7'd0, 6'd0, FL_NONE), ROW_TEXT, "0");
        add_row(item_of(32'hFFFF_FFFF, 6'd16, 7'd0, 6'd0, FL_NONE), ROW_TEXT, "ffffffff");
        add_row(item_of(32'hFFFF_FFFF, 6'd16, 7'd0, 6'd0, FL_ALT | FL_UPPER),
                ROW_TEXT, "0XFFFFFFFF");
        add_row(item_of(32'h8000_0000, 6'd10, 7'd0, 6'd0, FL_SIGNED), ROW_TEXT, "-2147483648");
        add_row(item_of(32'h7FFF_FFFF, 6'd10, 7'd0, 6'd0, FL_SIGNED | FL_PLUS),
                ROW_TEXT, "+2147483647");
        add_row(item_of(32'd0, 6'd10, 7'd0, 6'd0, FL_SIGNED | FL_SPACE), ROW_TEXT, " 0");
        add_row(item_of(32'd42, 6'd10, 7'd0, 6'd0, FL_PLUS | FL_SPACE), ROW_TEXT, "42");
        add_row(item_of(32'hFFFF_FFFF, 6'd2, 7'd0, 6'd0, FL_NONE),
                ROW_TEXT, "11111111111111111111111111111111");
        add_row(item_of(32'd35, 6'd36, 7'd0, 6'd0, FL_NONE), ROW_TEXT, "z");
        add_row(item_of(32'd35, 6'd36, 7'd0, 6'd0, FL_UPPER), ROW_TEXT, "Z");
        add_row(item_of(32'd0, 6'd8, 7'd0, 6'd0, FL_ALT), ROW_TEXT, "00");
        add_row(item_of(32'd0, 6'd16, 7'd0, 6'd0, FL_ALT), ROW_TEXT, "0x0");
        add_row(item_of(32'd5, 6'd10, 7'd0, 6'd0, FL_ALT), ROW_TEXT, "5");
        add_row(item_of(32'hFFFF_FFFB, 6'd10, 7'd6, 6'd0, FL_SIGNED | FL_ZERO),
                ROW_TEXT, "-00005");
        add_row(item_of(32'd17, 6'd10, 7'd5, 6'd0, FL_LEFT), ROW_TEXT, "17   ");
        add_row(item_of(32'd17, 6'd10, 7'd5, 6'd0, FL_NONE), ROW_TEXT, "   17");
        add_row(item_of(32'd0, 6'd10, 7'd0, 6'd3, FL_NONE), ROW_TEXT, "000");
        add_row(item_of(32'd9, 6'd0, 7'd0, 6'd0, FL_NONE), ROW_ERROR, "");
        add_row(item_of(32'd9, 6'd1, 7'd0, 6'd0, FL_NONE), ROW_ERROR, "");
        add_row(item_of(32'd9, 6'd37, 7'd0, 6'd0, FL_NONE), ROW_ERROR, "");
        add_row(item_of(32'hFFFF_FFFF, 6'd63, 7'd127, 6'd63, 7'h7F), ROW_ERROR, "");
        add_row(item_of(32'd7, 6'd10, 7'd127, 6'd0, FL_NONE), ROW_PREDICT, "");
        add_row(item_of(32'd123, 6'd10, 7'd8, 6'd0, FL_ZERO | FL_LEFT), ROW_PREDICT, "");
        add_row(item_of(32'd42, 6'd10, 7'd10, 6'd5, FL_ZERO), ROW_PREDICT, "");
        add_row(item_of(32'd255, 6'd16, 7'd10, 6'd0, FL_ALT | FL_ZERO | FL_UPPER),
                ROW_PREDICT, "");
        add_row(item_of(32'd1, 6'd16, 7'd127, 6'd63,
                        FL_SIGNED | FL_PLUS | FL_ALT | FL_ZERO), ROW_PREDICT, "");
        add_row(item_of(32'hFFFF_FFFF, 6'd10, 7'd127, 6'd63,
                        FL_SIGNED | FL_SPACE | FL_LEFT), ROW_PREDICT, "");
    endfunction

    // Mostly short fields, in common and random bases, with the extremes mixed in
    function automatic rtt_in_t random_item();
        rtt_in_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            it.value = $urandom_range(0, 40);
        else if (pick < 22)
            it.value = 32'h8000_0000 + $urandom_range(0, 3);
        else if (pick < 29)
            it.value = 32'hFFFF_FFFF - $urandom_range(0, 3);
        else if (pick < 33)
            it.value = 32'h7FFF_FFFF - $urandom_range(0, 3);
        else
            it.value = $urandom;

        pick = $urandom_range(0, 99);
        if (pick < 4)
            it.base = 6'($urandom_range(0, 1));
        else if (pick < 8)
            it.base = 6'($urandom_range(37, 63));
        else if (pick < 45)
            it.base = (pick % 3 == 0) ? 6'd8 : (pick % 3 == 1) ? 6'd10 : 6'd16;
        else
            it.base = 6'($urandom_range(MIN_BASE, MAX_BASE));

        pick = $urandom_range(0, 99);
        if (pick < 70)
            it.width = 7'($urandom_range(0, 24));
        else if (pick < 90)
            it.width = 7'($urandom_range(25, 64));
        else
            it.width = 7'($urandom_range(65, 127));

        pick = $urandom_range(0, 99);
        if (pick < 55)
            it.precision = 6'd0;
        else if (pick < 85)
            it.precision = 6'($urandom_range(1, 20));
        else
            it.precision = 6'($urandom_range(21, 63));

        {it.is_signed, it.plus_sign, it.space_sign, it.left_justify,
         it.zero_pad, it.alt_prefix, it.upper_case} = 7'($urandom_range(0, 127));
        return it;
    endfunction

    // Offer one transaction; entered and left at a falling edge
    task automatic send_item(input rtt_in_t it, input row_kind_t kind, input string s);
        while (idle_on && $urandom_range(0, 99) < 36) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        items_sent++;
        if (it.base < MIN_BASE || it.base > MAX_BASE) bad_base_sent++;
        case (kind)
            ROW_TEXT:  expect_text(s);
            ROW_ERROR: expect_error();
            default:   predict_radix_text(it);
        endcase
        @(negedge aclk);
    endtask

    // Result side: random idling plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_results = 1'b0;
            end
            m_ready <= !(idle_on && $urandom_range(0, 99) < 36);
        end
    end

    // Compare each accepted character with the oldest expectation
    always @(posedge aclk) begin
        rtt_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: char %02h last %0b error %0b",
                             m_data.character, m_data.last, m_data.error);
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (m_data.character !== want.character || m_data.last !== want.last ||
                    m_data.error !== want.error) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: want char %02h last %0b error %0b, got %02h %0b %0b",
                                 chars_checked, want.character, want.last, want.error,
                                 m_data.character, m_data.last, m_data.error);
                end
            end
        end
    end

    // Abort when no transaction moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     stall_cycles, expected_chars.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        build_table();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (table_items[i]) send_item(table_items[i], table_kinds[i], table_texts[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Stall the receiver while items keep coming
            if (n == 150) hold_results = 1'b1;
            // Run a stretch at full rate on both sides
            if (n == 200) idle_on = 1'b0;
            if (n == 280) idle_on = 1'b1;
            // Drain everything before going on
            if (n == 320) begin
                s_valid <= 1'b0;
                wait (expected_chars.size() == 0);
                @(negedge aclk);
            end
            send_item(random_item(), ROW_PREDICT, "");
        end
        s_valid <= 1'b0;

        wait (expected_chars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        mismatches += expected_chars.size();

        $display("Converted %0d integers (%0d with a bad base), %0d characters checked",
                 items_sent, bad_base_sent, chars_checked);
        $display("across bases 2 to 36, all sign, prefix, padding and precision flags.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
